/* sv/otq_pkg.sv */
// Shared types and constants of the ordered timer queue.
`timescale 1ns / 1ps

package otq_pkg;

    // Field widths of the stream items.
    localparam int OP_W     = 2;
    localparam int ID_W     = 4;
    localparam int DELAY_W  = 32;
    localparam int REMAIN_W = 32;
    localparam int TDATA_W  = 40;
    localparam int PAD_W    = TDATA_W - ID_W - DELAY_W;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_mode_t;

endpackage

/* sv/otq_alu.sv */
// Shared add/subtract unit with a zero test and an unsigned compare against a limit.
`timescale 1ns / 1ps

module otq_alu
    import otq_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  alu_mode_t        mode,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] limit,
    output logic [WIDTH-1:0] result,
    output logic             is_zero,
    output logic             at_least
);

    always_comb begin
        unique case (mode)
            ALU_ADD: result = op_a + op_b;
            ALU_SUB: result = op_a - op_b;
            default: result = op_a - op_b;
        endcase
    end

    assign is_zero  = (result == '0);
    assign at_least = (result >= limit);

endmodule

/* sv/ordered_timer_queue.sv */
// Top level: timer slots in a linked queue sorted by remaining ticks, walked by a sequencer.
//
//  Channel | Dir | tdata (low bit up)                       | tuser         | tlast
//  s_      | in  | timer_id[3:0], delay[35:4], zero pad      | operation     | -
//  m_      | out | expired_id[3:0], remaining[35:4], pad     | expired_valid | last
//
// One item is in work at a time; s_tready is high only while the sequencer idles.
// A set of an armed slot walks the list to unlink it and again to insert it; a cancel walks it
// to unlink only. The list walks visit one entry per cycle through the single read port of the
// expiry and link memories, but a tick's walk waits while a result is held for a busy output.
// Synchronous active-low reset empties the queue and clears the counter; no clearing pass.
// A result waiting in the output register stalls the sequencer only when it must push again.
`timescale 1ns / 1ps

module ordered_timer_queue
    import otq_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // timer_id, delay, zero pad
    input  logic [OP_W-1:0]    s_tuser,   // operation
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // expired_id, remaining, zero pad
    output logic               m_tuser,   // expired_valid
    output logic               m_tlast
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LINK_W = $clog2(NUM_TIMERS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_TIMERS);

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_TICK_INC   = 11'b000_0000_0010,
        S_TICK_CMP   = 11'b000_0000_0100,
        S_TICK_FLUSH = 11'b000_0000_1000,
        S_UL_START   = 11'b000_0001_0000,
        S_UL_STEP    = 11'b000_0010_0000,
        S_IN_START   = 11'b000_0100_0000,
        S_IN_STEP    = 11'b000_1000_0000,
        S_IN_LINK    = 11'b001_0000_0000,
        S_Q_RD       = 11'b010_0000_0000,
        S_Q_OUT      = 11'b100_0000_0000
    } state_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [COUNT_WIDTH-1:0]  dly_reg, dly_next;
    logic [COUNT_WIDTH-1:0]  counter_reg, counter_next;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [LINK_W-1:0]       cur_reg, cur_next;
    logic [LINK_W-1:0]       prev_reg, prev_next;
    logic [NUM_TIMERS-1:0]   armed_reg, armed_next;
    logic [IDX_W-1:0]        pend_reg, pend_next;
    logic                    pend_valid_reg, pend_valid_next;

    logic                    m_valid_reg;
    logic [ID_W-1:0]         m_id_reg;
    logic [REMAIN_W-1:0]     m_rem_reg;
    logic                    m_exp_reg;
    logic                    m_last_reg;

    logic [COUNT_WIDTH-1:0]  exp_mem [NUM_TIMERS];
    logic [LINK_W-1:0]       link_mem [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0]  exp_rd_reg;
    logic [LINK_W-1:0]       link_rd_reg;

    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    exp_we;
    logic [IDX_W-1:0]        exp_waddr;
    logic [COUNT_WIDTH-1:0]  exp_wdata;
    logic                    link_we;
    logic [IDX_W-1:0]        link_waddr;
    logic [LINK_W-1:0]       link_wdata;

    logic                    push;
    logic [ID_W-1:0]         push_id;
    logic [REMAIN_W-1:0]     push_rem;
    logic                    push_exp;
    logic                    push_last;
    logic                    out_free;

    alu_mode_t               alu_mode;
    logic [COUNT_WIDTH-1:0]  alu_a;
    logic [COUNT_WIDTH-1:0]  alu_b;
    logic [COUNT_WIDTH-1:0]  alu_result;
    logic                    alu_zero;
    logic                    alu_ge;

    op_t                     in_op;
    logic [ID_W-1:0]         in_id;
    logic [COUNT_WIDTH-1:0]  in_dly;
    logic                    in_ok;
    logic [IDX_W-1:0]        in_idx;
    logic                    id_ok;
    logic [IDX_W-1:0]        id_idx;
    logic [LINK_W-1:0]       id_link;

    assign in_op   = op_t'(s_tuser);
    assign in_id   = s_tdata[ID_W-1:0];
    assign in_dly  = COUNT_WIDTH'(s_tdata[ID_W +: DELAY_W]);
    assign in_ok   = (int'(in_id) < NUM_TIMERS);
    assign in_idx  = IDX_W'(in_id);
    assign id_ok   = (int'(id_reg) < NUM_TIMERS);
    assign id_idx  = IDX_W'(id_reg);
    assign id_link = LINK_W'(id_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    // The adder forms the new expiry on insert; otherwise it measures ticks left.
    assign alu_mode = (state_reg == S_IN_START) ? ALU_ADD : ALU_SUB;
    assign alu_a    = (state_reg == S_IN_START) ? counter_reg : exp_rd_reg;
    assign alu_b    = (state_reg == S_IN_START) ? dly_reg : counter_reg;

    otq_alu #(
        .WIDTH (COUNT_WIDTH)
    ) u_alu (
        .mode     (alu_mode),
        .op_a     (alu_a),
        .op_b     (alu_b),
        .limit    (dly_reg),
        .result   (alu_result),
        .is_zero  (alu_zero),
        .at_least (alu_ge)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        dly_next        = dly_reg;
        counter_next    = counter_reg;
        head_next       = head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        armed_next      = armed_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rd_en           = 1'b0;
        rd_addr         = IDX_W'(cur_reg);
        exp_we          = 1'b0;
        exp_waddr       = id_idx;
        exp_wdata       = alu_result;
        link_we         = 1'b0;
        link_waddr      = id_idx;
        link_wdata      = NIL;
        push            = 1'b0;
        push_id         = '0;
        push_rem        = '0;
        push_exp        = 1'b0;
        push_last       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next  = in_op;
                    id_next  = in_id;
                    dly_next = in_dly;
                    unique case (in_op)
                        OP_TICK: state_next = S_TICK_INC;
                        OP_SET: begin
                            if (in_ok && (in_dly != '0)) begin
                                state_next = armed_reg[in_idx] ? S_UL_START : S_IN_START;
                            end
                        end
                        OP_CANCEL: begin
                            if (in_ok && armed_reg[in_idx]) begin
                                state_next = S_UL_START;
                            end
                        end
                        OP_QUERY: state_next = S_Q_RD;
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            S_TICK_INC: begin
                counter_next    = counter_reg + 1'b1;
                pend_valid_next = 1'b0;
                if (head_reg == NIL) begin
                    state_next = S_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(head_reg);
                    cur_next   = head_reg;
                    state_next = S_TICK_CMP;
                end
            end

            // A removed slot is held back until the next entry is compared, so its last flag is known.
            S_TICK_CMP: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        push      = 1'b1;
                        push_exp  = 1'b1;
                        push_id   = ID_W'(pend_reg);
                        push_last = !alu_zero;
                    end
                    if (alu_zero) begin
                        pend_next                    = IDX_W'(cur_reg);
                        pend_valid_next              = 1'b1;
                        head_next                    = link_rd_reg;
                        armed_next[IDX_W'(cur_reg)]  = 1'b0;
                        if (link_rd_reg == NIL) begin
                            state_next = S_TICK_FLUSH;
                        end else begin
                            rd_en    = 1'b1;
                            rd_addr  = IDX_W'(link_rd_reg);
                            cur_next = link_rd_reg;
                        end
                    end else begin
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_TICK_FLUSH: begin
                if (out_free) begin
                    push            = 1'b1;
                    push_exp        = 1'b1;
                    push_id         = ID_W'(pend_reg);
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            S_UL_START: begin
                armed_next[id_idx] = 1'b0;
                cur_next           = head_reg;
                prev_next          = NIL;
                rd_en              = 1'b1;
                rd_addr            = IDX_W'(head_reg);
                state_next         = S_UL_STEP;
            end

            S_UL_STEP: begin
                if (cur_reg == id_link) begin
                    if (prev_reg == NIL) begin
                        head_next = link_rd_reg;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = IDX_W'(prev_reg);
                        link_wdata = link_rd_reg;
                    end
                    state_next = (op_reg == OP_SET) ? S_IN_START : S_IDLE;
                end else if (link_rd_reg == NIL) begin
                    state_next = (op_reg == OP_SET) ? S_IN_START : S_IDLE;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = link_rd_reg;
                    rd_en     = 1'b1;
                    rd_addr   = IDX_W'(link_rd_reg);
                end
            end

            S_IN_START: begin
                exp_we    = 1'b1;
                exp_waddr = id_idx;
                exp_wdata = alu_result;
                cur_next  = head_reg;
                prev_next = NIL;
                if (head_reg == NIL) begin
                    link_we    = 1'b1;
                    link_waddr = id_idx;
                    link_wdata = NIL;
                    state_next = S_IN_LINK;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_W'(head_reg);
                    state_next = S_IN_STEP;
                end
            end

            // The new slot goes before the first entry with at least as many ticks left.
            S_IN_STEP: begin
                if (alu_ge) begin
                    link_we    = 1'b1;
                    link_waddr = id_idx;
                    link_wdata = cur_reg;
                    state_next = S_IN_LINK;
                end else begin
                    prev_next = cur_reg;
                    if (link_rd_reg == NIL) begin
                        link_we    = 1'b1;
                        link_waddr = id_idx;
                        link_wdata = NIL;
                        state_next = S_IN_LINK;
                    end else begin
                        cur_next = link_rd_reg;
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(link_rd_reg);
                    end
                end
            end

            S_IN_LINK: begin
                if (prev_reg == NIL) begin
                    head_next = id_link;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = IDX_W'(prev_reg);
                    link_wdata = id_link;
                end
                armed_next[id_idx] = 1'b1;
                state_next         = S_IDLE;
            end

            S_Q_RD: begin
                rd_en      = 1'b1;
                rd_addr    = id_idx;
                state_next = S_Q_OUT;
            end

            S_Q_OUT: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    push_rem   = (id_ok && armed_reg[id_idx]) ? REMAIN_W'(alu_result) : '0;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            counter_reg    <= '0;
            head_reg       <= NIL;
            armed_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            counter_reg    <= counter_next;
            head_reg       <= head_next;
            armed_reg      <= armed_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        id_reg   <= id_next;
        dly_reg  <= dly_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (exp_we) begin
            exp_mem[exp_waddr] <= exp_wdata;
        end
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en) begin
            exp_rd_reg  <= exp_mem[rd_addr];
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_id_reg   <= push_id;
            m_rem_reg  <= push_rem;
            m_exp_reg  <= push_exp;
            m_last_reg <= push_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_rem_reg, m_id_reg};
    assign m_tuser  = m_exp_reg;
    assign m_tlast  = m_last_reg;

    // No expired slot may still be held back once the sequencer is idle.
    a_no_pending_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("expired slot left pending while idle");

    // An empty queue has no armed slot.
    a_empty_queue_unarmed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_IDLE) && (head_reg == NIL)) |-> (armed_reg == '0))
        else $error("armed slot outside an empty queue");

    // A tick advances the counter by exactly one.
    a_tick_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK_INC) |=>
            (counter_reg == COUNT_WIDTH'($past(counter_reg) + 1'b1)))
        else $error("tick counter did not advance by one");

    // A query answer is always the only result of its item.
    a_query_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("query result without last");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the ordered timer queue, checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import otq_pkg::*;

    localparam int NT          = 16;
    localparam int END_OF_LIST = NT;
    localparam int DRAIN_WAIT  = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic        expired_valid;
        logic [3:0]  expired_id;
        logic [31:0] remaining;
        logic        last;
    } timer_result_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // timer_id, delay, zero pad
    logic [OP_W-1:0]    s_tuser;   // operation
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // expired_id, remaining, zero pad
    logic               m_tuser;   // expired_valid
    logic               m_tlast;

    // Predicted timer state.
    logic [31:0] tick_count;
    logic [31:0] expiry_at [NT];
    logic        slot_armed [NT];
    int          next_slot [NT];
    int          list_head;

    timer_result_t pending_results[$];
    int            error_count;
    int            items_sent;
    int            cycle_count;
    bit            idle_on;

    ordered_timer_queue #(
        .NUM_TIMERS  (NT),
        .COUNT_WIDTH (32)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void unlink_timer(int id);
        int prev;
        int cur;
        int guard;
        prev = END_OF_LIST;
        cur  = list_head;
        if (!slot_armed[id])
            return;
        slot_armed[id] = 1'b0;
        for (guard = 0; guard < NT && cur < NT; guard++) begin
            if (cur == id) begin
                if (prev == END_OF_LIST)
                    list_head = next_slot[cur];
                else
                    next_slot[prev] = next_slot[cur];
                return;
            end
            prev = cur;
            cur  = next_slot[cur];
        end
    endfunction

    function automatic void insert_timer(int id, logic [31:0] dly);
        int prev;
        int cur;
        int guard;
        logic [31:0] left;
        prev = END_OF_LIST;
        cur  = list_head;
        expiry_at[id] = tick_count + dly;
        // The new timer goes ahead of the first entry with at least as many ticks left.
        for (guard = 0; guard < NT && cur < NT; guard++) begin
            left = expiry_at[cur] - tick_count;
            if (left >= dly)
                break;
            prev = cur;
            cur  = next_slot[cur];
        end
        next_slot[id] = cur;
        if (prev == END_OF_LIST)
            list_head = id;
        else
            next_slot[prev] = id;
        slot_armed[id] = 1'b1;
    endfunction

    function automatic void predict_timer_op(op_t op, logic [3:0] id, logic [31:0] dly);
        timer_result_t res;
        int n;
        int h;
        bit more;
        n = 0;
        case (op)
            OP_TICK: begin
                tick_count = tick_count + 1;
                more = (list_head < NT) && (expiry_at[list_head] == tick_count);
                while (more) begin
                    h = list_head;
                    list_head = next_slot[h];
                    slot_armed[h] = 1'b0;
                    n++;
                    more = (n < NT) && (list_head < NT) && (expiry_at[list_head] == tick_count);
                    res.expired_valid = 1'b1;
                    res.expired_id    = h[3:0];
                    res.remaining     = '0;
                    res.last          = !more;
                    pending_results.push_back(res);
                end
            end
            OP_SET: begin
                if (dly != 0) begin
                    unlink_timer(int'(id));
                    insert_timer(int'(id), dly);
                end
            end
            OP_CANCEL: begin
                unlink_timer(int'(id));
            end
            default: begin
                res.expired_valid = 1'b0;
                res.expired_id    = '0;
                res.remaining     = slot_armed[id] ? (expiry_at[id] - tick_count) : '0;
                res.last          = 1'b1;
                pending_results.push_back(res);
            end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the item was accepted.
    task automatic send_item(op_t op, logic [3:0] id, logic [31:0] dly);
        while (idle_on && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, dly, id};
        do
            @(posedge aclk);
        while (!s_tready);
        predict_timer_op(op, id, dly);
        items_sent++;
    endtask

    task automatic test_basic_ops();
        send_item(OP_QUERY,  4'd5,  32'd0);
        send_item(OP_SET,    4'd0,  32'd1);
        send_item(OP_SET,    4'd15, 32'hFFFF_FFFF);
        send_item(OP_SET,    4'd3,  32'd2);
        send_item(OP_SET,    4'd4,  32'd2);
        send_item(OP_SET,    4'd9,  32'd0);
        send_item(OP_SET,    4'd3,  32'd0);
        send_item(OP_QUERY,  4'd3,  32'd0);
        send_item(OP_QUERY,  4'd15, 32'd0);
        send_item(OP_CANCEL, 4'd7,  32'd0);
        send_item(OP_SET,    4'd10, 32'h8000_0000);
        send_item(OP_SET,    4'd10, 32'd5);
        send_item(OP_QUERY,  4'd10, 32'd0);
        send_item(OP_TICK,   4'd0,  32'd0);
        // Slots 4 and 3 share an expiry, so one tick reports both in list order.
        send_item(OP_TICK,   4'd0,  32'd0);
        send_item(OP_QUERY,  4'd10, 32'd0);
        send_item(OP_CANCEL, 4'd10, 32'd0);
        send_item(OP_QUERY,  4'd10, 32'd0);
        send_item(OP_TICK,   4'd0,  32'd0);
        send_item(OP_CANCEL, 4'd15, 32'd0);
        send_item(OP_QUERY,  4'd15, 32'd0);
        send_item(OP_SET,    4'd12, 32'h5555_5555);
        send_item(OP_SET,    4'd6,  32'hAAAA_AAAA);
        send_item(OP_QUERY,  4'd6,  32'd0);
        send_item(OP_QUERY,  4'd12, 32'd0);
    endtask

    // Arms every slot for the same tick, in a shuffled order, so one tick empties the list.
    task automatic test_simultaneous_expiry();
        int order [NT];
        int i;
        int j;
        int t;
        logic [31:0] dly;
        for (i = 0; i < NT; i++)
            order[i] = i;
        for (i = NT - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        dly = $urandom_range(1, 3);
        for (i = 0; i < NT; i++)
            send_item(OP_SET, order[i][3:0], dly);
        repeat (dly)
            send_item(OP_TICK, 4'd0, 32'd0);
    endtask

    task automatic test_random_traffic(int count);
        int stop_at;
        int k;
        logic [31:0] dly;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                // Arm a few timers with short delays, then send ticks, which may expire some of them.
                repeat ($urandom_range(1, 5)) begin
                    send_item(OP_SET, 4'($urandom_range(NT - 1)), $urandom_range(1, 6));
                    if ($urandom_range(99) < 25)
                        send_item(OP_QUERY, 4'($urandom_range(NT - 1)), 32'd0);
                    if ($urandom_range(99) < 15)
                        send_item(OP_CANCEL, 4'($urandom_range(NT - 1)), 32'd0);
                end
                repeat ($urandom_range(1, 7)) begin
                    send_item(OP_TICK, 4'($urandom_range(NT - 1)), $urandom);
                    if ($urandom_range(99) < 20)
                        send_item(OP_QUERY, 4'($urandom_range(NT - 1)), $urandom);
                end
            end else begin
                k = $urandom_range(3);
                case (k)
                    0:       dly = 32'd0;
                    1:       dly = $urandom;
                    2:       dly = $urandom_range(1, 10);
                    default: dly = 32'hFFFF_FFFF - $urandom_range(3);
                endcase
                send_item(op_t'($urandom_range(3)), 4'($urandom_range(NT - 1)), dly);
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= (idle_on && $urandom_range(99) < 32) ? 1'b0 : 1'b1;
    end

    always @(posedge aclk) begin
        timer_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result id=%h remaining=%h", $time,
                         m_tdata[3:0], m_tdata[35:4]);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tuser !== exp_res.expired_valid) begin
                    $display("%0t: expired_valid expected %b actual %b", $time,
                             exp_res.expired_valid, m_tuser);
                    error_count++;
                end
                if (m_tdata[3:0] !== exp_res.expired_id) begin
                    $display("%0t: expired_id expected %h actual %h", $time,
                             exp_res.expired_id, m_tdata[3:0]);
                    error_count++;
                end
                if (m_tdata[35:4] !== exp_res.remaining) begin
                    $display("%0t: remaining expected %h actual %h", $time,
                             exp_res.remaining, m_tdata[35:4]);
                    error_count++;
                end
                if (m_tlast !== exp_res.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             exp_res.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int i;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= OP_TICK;
        m_tready    <= 1'b0;
        idle_on     = 1'b1;
        error_count = 0;
        items_sent  = 0;
        cycle_count = 0;
        tick_count  = '0;
        list_head   = END_OF_LIST;
        for (i = 0; i < NT; i++) begin
            slot_armed[i] = 1'b0;
            expiry_at[i]  = '0;
            next_slot[i]  = END_OF_LIST;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_random_traffic(70);
        idle_on = 1'b0;
        test_simultaneous_expiry();
        test_random_traffic(40);
        idle_on = 1'b1;
        test_random_traffic(60);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* ordered_timer_queue.f */
sv/otq_pkg.sv
sv/otq_alu.sv
sv/ordered_timer_queue.sv
tb/tb_top.sv
